>>> rtl/core/biou_pkg.sv
package biou_pkg;

   localparam int MaxTracks = 64;
   localparam int SlotBits  = $clog2(MaxTracks);
   localparam int CountBits = SlotBits + 1;
   localparam int QBits     = 17;
   localparam int DivSteps  = QBits;

   localparam logic [QBits-1:0] CostOne = QBits'(65536);

   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_DETECT = 1'b1;

   localparam logic REG_TRACK_COUNT = 1'b0;

   typedef struct packed {
      logic               op;
      logic [5:0]         slot;
      logic signed [15:0] box_left;
      logic signed [15:0] box_top;
      logic [14:0]        box_width;
      logic [14:0]        box_height;
   } req_type;

   typedef struct packed {
      logic [5:0]  track_index;
      logic [16:0] cost;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic signed [15:0] left;
      logic signed [15:0] top;
      logic [14:0]        width;
      logic [14:0]        height;
   } box_type;

endpackage

>>> rtl/core/box_iou_cost_matrix.sv
// After a detection transfer its costs follow, one cost per cycle unless the output stalls.
// A detection holds the input until it has issued track_count tracks (64 at most), one per
// cycle while the output advances, set by the single track store read port; a load gives no result.
// Reset (synchronous, active high) clears valid bits, the sequencer and track_count;
// the track store is not cleared and must be loaded before use.
module box_iou_cost_matrix
   import biou_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic                 adv;
   logic                 req_fire;
   logic [6:0]           track_count_ff;
   logic [CountBits-1:0] lim;
   logic                 busy_ff, busy_in;
   logic [SlotBits-1:0]  idx_ff, idx_in;
   box_type              det_ff;
   logic                 issue, issue_last;

   box_type              track_mem [0:MaxTracks-1];

   // stage 1: store read
   logic                 v1_ff;
   logic [SlotBits-1:0]  i1_ff;
   logic                 l1_ff;
   box_type              t1_ff, d1_ff;
   // stage 2: overlaps
   logic                 v2_ff;
   logic [SlotBits-1:0]  i2_ff;
   logic                 l2_ff;
   logic [14:0]          ow_ff, oh_ff, tw_ff, th_ff, dw_ff, dh_ff;
   logic [14:0]          ow_in, oh_in;
   logic signed [16:0]   xlo, xhi, ylo, yhi, tea, dea, teb, deb;
   // stage 3: products
   logic                 v3_ff;
   logic [SlotBits-1:0]  i3_ff;
   logic                 l3_ff;
   logic [29:0]          inter3_ff, ta3_ff, da3_ff;
   // stage 4: union
   logic                 v4_ff;
   logic [SlotBits-1:0]  i4_ff;
   logic                 l4_ff;
   logic [29:0]          inter4_ff;
   logic [31:0]          uni4_ff;
   logic [47:0]          num;
   // divider stages
   logic                 dv_ff   [0:DivSteps];
   logic [SlotBits-1:0]  di_ff   [0:DivSteps];
   logic                 dl_ff   [0:DivSteps];
   logic                 dz_ff   [0:DivSteps];
   logic [32:0]          dr_ff   [0:DivSteps];
   logic [QBits-1:0]     dq_ff   [0:DivSteps];
   logic [QBits-1:0]     dn_ff   [0:DivSteps];
   logic [31:0]          du_ff   [0:DivSteps];
   // output
   logic                 rsp_valid_ff;
   rsp_type              rsp_data_ff;

   assign adv       = ~rsp_valid_ff | ~rsp_stall;
   assign req_stall = busy_ff | ~adv;
   assign req_fire  = req_valid & ~req_stall;
   assign lim       = (track_count_ff > 7'(MaxTracks)) ? CountBits'(MaxTracks)
                                                     : CountBits'(track_count_ff);

   assign csr_pready = 1'b1;
   assign csr_prdata = {25'b0, track_count_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         track_count_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr[2] == REG_TRACK_COUNT) begin
         track_count_ff <= csr_pwdata[6:0];
      end
   end

   // sequencer
   assign issue      = busy_ff & adv;
   assign issue_last = ({1'b0, idx_ff} == lim - CountBits'(1));

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (req_fire && req_data.op == OP_DETECT && lim != '0) begin
         busy_in = 1'b1;
         idx_in  = '0;
      end else if (issue) begin
         if (issue_last) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + SlotBits'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && req_data.op == OP_DETECT) begin
         det_ff <= '{req_data.box_left, req_data.box_top,
                     req_data.box_width, req_data.box_height};
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && req_data.op == OP_LOAD) begin
         track_mem[req_data.slot] <= '{req_data.box_left, req_data.box_top,
                                       req_data.box_width, req_data.box_height};
      end
      if (adv) begin
         t1_ff <= track_mem[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         i1_ff <= idx_ff;
         l1_ff <= issue_last;
         d1_ff <= det_ff;
      end
   end

   // overlap lengths
   always_comb begin
      tea   = 17'({t1_ff.left[15], t1_ff.left}) + 17'({2'b0, t1_ff.width});
      dea   = 17'({d1_ff.left[15], d1_ff.left}) + 17'({2'b0, d1_ff.width});
      teb   = 17'({t1_ff.top[15], t1_ff.top}) + 17'({2'b0, t1_ff.height});
      deb   = 17'({d1_ff.top[15], d1_ff.top}) + 17'({2'b0, d1_ff.height});
      xlo   = (t1_ff.left > d1_ff.left) ? 17'(t1_ff.left) : 17'(d1_ff.left);
      ylo   = (t1_ff.top > d1_ff.top) ? 17'(t1_ff.top) : 17'(d1_ff.top);
      xhi   = (tea < dea) ? tea : dea;
      yhi   = (teb < deb) ? teb : deb;
      ow_in = (xhi > xlo) ? 15'(xhi - xlo) : '0;
      oh_in = (yhi > ylo) ? 15'(yhi - ylo) : '0;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         i2_ff <= i1_ff;
         l2_ff <= l1_ff;
         ow_ff <= ow_in;
         oh_ff <= oh_in;
         tw_ff <= t1_ff.width;
         th_ff <= t1_ff.height;
         dw_ff <= d1_ff.width;
         dh_ff <= d1_ff.height;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         i3_ff     <= i2_ff;
         l3_ff     <= l2_ff;
         inter3_ff <= ow_ff * oh_ff;
         ta3_ff    <= tw_ff * th_ff;
         da3_ff    <= dw_ff * dh_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         i4_ff     <= i3_ff;
         l4_ff     <= l3_ff;
         inter4_ff <= inter3_ff;
         uni4_ff   <= 32'(ta3_ff) + 32'(da3_ff) - 32'(inter3_ff);
      end
   end

   // rounded numerator: inter * 2^16 + union / 2
   assign num = {2'b0, inter4_ff, 16'b0} + {17'b0, uni4_ff[31:1]};

   always_ff @(posedge clock) begin
      if (adv) begin
         di_ff[0] <= i4_ff;
         dl_ff[0] <= l4_ff;
         dz_ff[0] <= (uni4_ff == '0);
         dr_ff[0] <= {2'b0, num[47:17]};
         dq_ff[0] <= '0;
         dn_ff[0] <= num[16:0];
         du_ff[0] <= uni4_ff;
         for (int k = 0; k < DivSteps; k++) begin
            logic [32:0] t;
            t = {dr_ff[k][31:0], dn_ff[k][QBits-1]};
            di_ff[k+1] <= di_ff[k];
            dl_ff[k+1] <= dl_ff[k];
            dz_ff[k+1] <= dz_ff[k];
            du_ff[k+1] <= du_ff[k];
            dn_ff[k+1] <= {dn_ff[k][QBits-2:0], 1'b0};
            if (t >= {1'b0, du_ff[k]}) begin
               dr_ff[k+1] <= t - {1'b0, du_ff[k]};
               dq_ff[k+1] <= {dq_ff[k][QBits-2:0], 1'b1};
            end else begin
               dr_ff[k+1] <= t;
               dq_ff[k+1] <= {dq_ff[k][QBits-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         for (int k = 0; k <= DivSteps; k++) begin
            dv_ff[k] <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v1_ff    <= issue;
         v2_ff    <= v1_ff;
         v3_ff    <= v2_ff;
         v4_ff    <= v3_ff;
         dv_ff[0] <= v4_ff;
         for (int k = 0; k < DivSteps; k++) begin
            dv_ff[k+1] <= dv_ff[k];
         end
         rsp_valid_ff <= dv_ff[DivSteps];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff.track_index <= di_ff[DivSteps];
         rsp_data_ff.last        <= dl_ff[DivSteps];
         rsp_data_ff.cost        <= dz_ff[DivSteps] ? CostOne : CostOne - dq_ff[DivSteps];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> verif/testbench.sv
module testbench
   import biou_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CycleLimit = 20000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b1;
   rsp_type     rsp_data;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   box_iou_cost_matrix dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   req_type  pending_reqs[$];
   rsp_type  expected_costs[$];
   box_type  track_store[MaxTracks];
   bit       gen_loaded[MaxTracks];
   logic [6:0] active_count = '0;
   bit       offer_held = 0;
   int       send_gap = 0;
   int       stall_left = 0;
   int       hold_left = 0;
   bit       hold_req = 0;
   bit       hold_seen = 0;
   int       errors = 0;
   int       cycles = 0;
   int       loads_sent = 0;
   int       dets_sent = 0;
   int       costs_checked = 0;

   function automatic longint overlap(longint a0, longint alen, longint b0, longint blen);
      longint lo, hi;
      lo = (a0 > b0) ? a0 : b0;
      hi = (a0 + alen < b0 + blen) ? a0 + alen : b0 + blen;
      return (hi > lo) ? hi - lo : 0;
   endfunction

   function automatic logic [16:0] iou_cost(box_type trk, req_type det);
      longint inter, uni, q;
      inter = overlap(trk.left, trk.width, det.box_left, det.box_width) *
              overlap(trk.top, trk.height, det.box_top, det.box_height);
      uni = longint'(trk.width) * trk.height + longint'(det.box_width) * det.box_height
            - inter;
      if (uni == 0) return CostOne;
      q = (inter * 65536 + uni / 2) / uni;
      if (q > 65536) q = 65536;
      return 17'(65536 - q);
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 20);
      return $urandom_range(50, 150);
   endfunction

   // input transfers: apply to the predictor in acceptance order
   always @(posedge clock) begin
      if (!reset) cycles <= cycles + 1;
      if (!reset && req_valid && !req_stall) begin
         req_type it;
         int n;
         it = pending_reqs.pop_front();
         offer_held = 0;
         if (it.op == OP_LOAD) begin
            track_store[it.slot] = {it.box_left, it.box_top, it.box_width, it.box_height};
            loads_sent++;
         end else begin
            dets_sent++;
            n = (active_count > MaxTracks) ? MaxTracks : active_count;
            for (int i = 0; i < n; i++)
               expected_costs.insert(expected_costs.size(),
                                     '{track_index: 6'(i),
                                       cost: iou_cost(track_store[i], it),
                                       last: (i == n - 1)});
         end
      end
   end

   always @(negedge clock) begin
      if (!reset && !offer_held) begin
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            req_valid <= 1'b1;
            req_data <= pending_reqs[0];
            offer_held = 1;
            send_gap <= pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stalls; one long hold-off lets the block back up into its input
   always @(negedge clock) begin
      if (hold_req && !hold_seen) begin
         hold_seen = 1;
         hold_left = 400;
      end
      if (reset) begin
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         if ($urandom_range(3) == 0) stall_left = pick_gap();
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_costs.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected cost: index %0d cost %0d last %0d",
                        rsp_data.track_index, rsp_data.cost, rsp_data.last);
         end else begin
            rsp_type want;
            want = expected_costs.pop_front();
            costs_checked++;
            if (rsp_data.track_index !== want.track_index || rsp_data.cost !== want.cost ||
                rsp_data.last !== want.last) begin
               errors++;
               if (errors <= 10)
                  $display("cost mismatch: expected idx %0d cost %0d last %0d, got %0d %0d %0d",
                           want.track_index, want.cost, want.last,
                           rsp_data.track_index, rsp_data.cost, rsp_data.last);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (cycles >= CycleLimit) begin
         $display("timeout after %0d cycles", cycles);
         $display("testbench: errors");
         $finish;
      end
   end

   function automatic req_type box_item(logic op, int slot, int l, int t, int w, int h);
      req_type it;
      it.op = op;
      it.slot = 6'(slot);
      it.box_left = 16'(l);
      it.box_top = 16'(t);
      it.box_width = 15'(w);
      it.box_height = 15'(h);
      return it;
   endfunction

   function automatic int rand_size();
      case ($urandom_range(5))
         0: return 0;
         1: return 32767;
         2: return $urandom_range(32767);
         default: return $urandom_range(1, 400);
      endcase
   endfunction

   task automatic queue_item(req_type it);
      if (it.op == OP_LOAD) gen_loaded[it.slot] = 1;
      pending_reqs.insert(pending_reqs.size(), it);
   endtask

   task automatic drain();
      wait (pending_reqs.size() == 0 && !offer_held && expected_costs.size() == 0);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_count(int value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= 3'(REG_TRACK_COUNT * 4);
      csr_pwdata <= 32'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      active_count = 7'(value);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // random phase: fill any slot a detection would read, then mix loads and detections
   task automatic random_phase(int count, int items);
      int n;
      req_type it;
      write_count(count);
      n = (count > MaxTracks) ? MaxTracks : count;
      for (int s = 0; s < n; s++)
         if (!gen_loaded[s])
            queue_item(box_item(OP_LOAD, s, $urandom, $urandom, rand_size(), rand_size()));
      for (int k = 0; k < items; k++) begin
         if ($urandom_range(2) == 0) begin
            queue_item(box_item(OP_LOAD, $urandom_range(63), $urandom, $urandom,
                                rand_size(), rand_size()));
         end else if (n > 0 && $urandom_range(3) != 0) begin
            // land near a stored track so overlaps are common
            box_type b;
            b = track_store[$urandom_range(n - 1)];
            it = box_item(OP_DETECT, $urandom, int'(b.left) + $signed($urandom_range(64)) - 32,
                          int'(b.top) + $signed($urandom_range(64)) - 32,
                          int'(b.width) + $urandom_range(16), int'(b.height) + $urandom_range(16));
            queue_item(it);
         end else begin
            queue_item(box_item(OP_DETECT, $urandom, $urandom, $urandom,
                                rand_size(), rand_size()));
         end
         if (count == MaxTracks && k == 10) hold_req = 1;
      end
      drain();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_count(4);
      queue_item(box_item(OP_LOAD, 0, 0, 0, 16, 16));
      queue_item(box_item(OP_LOAD, 1, 0, 0, 0, 0));
      queue_item(box_item(OP_LOAD, 2, -32768, -32768, 32767, 32767));
      queue_item(box_item(OP_LOAD, 3, 32767, 32767, 32767, 32767));
      queue_item(box_item(OP_LOAD, 63, -1, 1, 5, 7));
      queue_item(box_item(OP_DETECT, 0, 0, 0, 16, 16));
      queue_item(box_item(OP_DETECT, 63, 16, 0, 16, 16));
      queue_item(box_item(OP_DETECT, 0, 0, 16, 16, 16));
      queue_item(box_item(OP_DETECT, 0, 0, 0, 0, 0));
      queue_item(box_item(OP_DETECT, 0, -32768, -32768, 32767, 32767));
      queue_item(box_item(OP_DETECT, 0, 32767, 32767, 32767, 32767));
      queue_item(box_item(OP_DETECT, 0, 8, 8, 16, 16));
      queue_item(box_item(OP_DETECT, 0, 100, -100, 0, 50));
      drain();

      write_count(0);
      queue_item(box_item(OP_DETECT, 0, 5, 5, 10, 10));
      queue_item(box_item(OP_LOAD, 10, 5, 5, 10, 10));
      drain();

      random_phase(64, 60);
      random_phase(127, 40);
      random_phase(1, 30);
      random_phase(0, 10);
      random_phase($urandom_range(2, 63), 40);
      random_phase(64, 30);

      $display("covered %0d loads and %0d detections, %0d costs checked",
               loads_sent, dets_sent, costs_checked);
      if (errors == 0) begin
         $display("testbench: clean");
      end else begin
         $display("%0d mismatches", errors);
         $display("testbench: errors");
      end
      $finish;
   end

endmodule
